[sv/rsag_pkg.sv]
`timescale 1ns / 1ps

package rsag_pkg;

	// Fixed field widths.
	localparam int COORD_W  = 13;
	localparam int DIM_W    = 14;
	localparam int TRIG_W   = 16;
	localparam int STRIDE_W = 16;
	localparam int OFFSET_W = 30;

	// Arithmetic widths of the angle datapath.
	localparam int CEN_W  = COORD_W + 1;      // centred coordinate, signed
	localparam int PROD_W = CEN_W + TRIG_W;   // one rotation product
	localparam int SUM_W  = PROD_W + 1;       // sum of two products
	localparam int POS_W  = 19;               // signed source position before the range check
	localparam int ROWP_W = COORD_W + STRIDE_W;
	localparam int COL3_W = COORD_W + 2;

	localparam int BYTES_PER_PIXEL = 3;
	localparam int TRIG_FRAC_BITS  = 14;
	localparam logic [DIM_W-1:0] MAX_DIM = DIM_W'(8192);

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		MODE_ROT90  = 2'd0,
		MODE_ROT180 = 2'd1,
		MODE_ROT270 = 2'd2,
		MODE_ANGLE  = 2'd3
	} rot_mode_t;

	// Register indexes (byte address is four times the index).
	localparam logic [2:0] REG_MODE       = 3'd0;
	localparam logic [2:0] REG_SRC_WIDTH  = 3'd1;
	localparam logic [2:0] REG_SRC_HEIGHT = 3'd2;
	localparam logic [2:0] REG_DST_WIDTH  = 3'd3;
	localparam logic [2:0] REG_DST_HEIGHT = 3'd4;
	localparam logic [2:0] REG_COS        = 3'd5;
	localparam logic [2:0] REG_SIN        = 3'd6;
	localparam logic [2:0] REG_STRIDE     = 3'd7;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 56;

endpackage

[sv/rotation_source_address_generator.sv]
`timescale 1ns / 1ps
// Six register stages, s1 to s6, lie between an input transfer and its result on the output port.
// Throughput: one transfer per cycle while the output side keeps tready high.
// Each stage holds its item while later stages are full, and bubbles close up under a stall.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the register defaults:
// quarter-turn mode, all sizes and stride one, cosine 1.0 and sine 0.

module rotation_source_address_generator
	import rsag_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [DATA_W-1:0]     pwdata,
	output logic [DATA_W-1:0]     prdata,
	output logic                  pready,

	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // dst_x[12:0], dst_y[25:13], zero fill

	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,   // src_col[12:0], src_row[25:13],
	                                              // src_offset[55:26]
	output logic                  m_axis_tuser    // in_range[0]
);

	// ------------------------------------------------------------------
	// Configuration registers. Writes complete on the access cycle; the
	// port never inserts wait states.
	// ------------------------------------------------------------------
	rot_mode_t                  mode_q;
	logic [DIM_W-1:0]           src_width_q;
	logic [DIM_W-1:0]           src_height_q;
	logic [DIM_W-1:0]           dst_width_q;
	logic [DIM_W-1:0]           dst_height_q;
	logic signed [TRIG_W-1:0]   cos_q;
	logic signed [TRIG_W-1:0]   sin_q;
	logic [STRIDE_W-1:0]        stride_q;

	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_ROT90;
			src_width_q  <= DIM_W'(1);
			src_height_q <= DIM_W'(1);
			dst_width_q  <= DIM_W'(1);
			dst_height_q <= DIM_W'(1);
			cos_q        <= TRIG_W'(1 << TRIG_FRAC_BITS);
			sin_q        <= '0;
			stride_q     <= STRIDE_W'(1);
		end else if (wr_en) begin
			case (reg_idx)
				REG_MODE:       mode_q       <= rot_mode_t'(pwdata[1:0]);
				REG_SRC_WIDTH:  src_width_q  <= pwdata[DIM_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= pwdata[DIM_W-1:0];
				REG_DST_WIDTH:  dst_width_q  <= pwdata[DIM_W-1:0];
				REG_DST_HEIGHT: dst_height_q <= pwdata[DIM_W-1:0];
				REG_COS:        cos_q        <= pwdata[TRIG_W-1:0];
				REG_SIN:        sin_q        <= pwdata[TRIG_W-1:0];
				REG_STRIDE:     stride_q     <= pwdata[STRIDE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MODE:       prdata = DATA_W'(mode_q);
			REG_SRC_WIDTH:  prdata = DATA_W'(src_width_q);
			REG_SRC_HEIGHT: prdata = DATA_W'(src_height_q);
			REG_DST_WIDTH:  prdata = DATA_W'(dst_width_q);
			REG_DST_HEIGHT: prdata = DATA_W'(dst_height_q);
			REG_COS:        prdata = DATA_W'($unsigned(cos_q));
			REG_SIN:        prdata = DATA_W'($unsigned(sin_q));
			REG_STRIDE:     prdata = DATA_W'(stride_q);
			default:        prdata = '0;
		endcase
	end

	// Source sizes above the largest supported dimension count as that
	// dimension. A zero size leaves every pixel out of range by itself.
	logic [DIM_W-1:0]         w_clamp;
	logic [DIM_W-1:0]         h_clamp;
	logic signed [POS_W-1:0]  w_pos;
	logic signed [POS_W-1:0]  h_pos;
	logic signed [POS_W-1:0]  w_half;
	logic signed [POS_W-1:0]  h_half;

	assign w_clamp = (src_width_q  > MAX_DIM) ? MAX_DIM : src_width_q;
	assign h_clamp = (src_height_q > MAX_DIM) ? MAX_DIM : src_height_q;
	assign w_pos   = POS_W'($signed({1'b0, w_clamp}));
	assign h_pos   = POS_W'($signed({1'b0, h_clamp}));
	assign w_half  = POS_W'($signed({2'b0, w_clamp[DIM_W-1:1]}));
	assign h_half  = POS_W'($signed({2'b0, h_clamp[DIM_W-1:1]}));

	// ------------------------------------------------------------------
	// Pipeline flow control. A stage loads when it is empty or when the
	// stage after it loads as well, so bubbles close up under a stall and
	// the input keeps flowing while a finished result waits at the output.
	// The user must change configuration only while the pipeline is empty
	// (the block does not check); every stage reads the registers directly.
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || m_axis_tready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign s_axis_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
			if (en6) begin
				v_s6 <= v_s5;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: centre the destination coordinate on the destination image
	// for the angle mode, and work out the exact quarter-turn mappings.
	// ------------------------------------------------------------------
	logic [COORD_W-1:0]       in_x;
	logic [COORD_W-1:0]       in_y;
	logic signed [POS_W-1:0]  x_pos;
	logic signed [POS_W-1:0]  y_pos;
	logic signed [POS_W-1:0]  dir_col;
	logic signed [POS_W-1:0]  dir_row;

	assign in_x  = s_axis_tdata[COORD_W-1:0];
	assign in_y  = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign x_pos = POS_W'($signed({1'b0, in_x}));
	assign y_pos = POS_W'($signed({1'b0, in_y}));

	always_comb begin
		case (mode_q)
			MODE_ROT90: begin
				dir_col = w_pos - POS_W'(1) - y_pos;
				dir_row = x_pos;
			end
			MODE_ROT180: begin
				dir_col = w_pos - POS_W'(1) - x_pos;
				dir_row = h_pos - POS_W'(1) - y_pos;
			end
			MODE_ROT270: begin
				dir_col = y_pos;
				dir_row = h_pos - POS_W'(1) - x_pos;
			end
			default: begin
				dir_col = '0;
				dir_row = '0;
			end
		endcase
	end

	logic signed [CEN_W-1:0]  cx_s1;
	logic signed [CEN_W-1:0]  cy_s1;
	logic signed [POS_W-1:0]  dcol_s1;
	logic signed [POS_W-1:0]  drow_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			cx_s1   <= CEN_W'($signed({1'b0, in_x})
				- $signed({2'b0, dst_width_q[DIM_W-1:1]}));
			cy_s1   <= CEN_W'($signed({1'b0, in_y})
				- $signed({2'b0, dst_height_q[DIM_W-1:1]}));
			dcol_s1 <= dir_col;
			drow_s1 <= dir_row;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: the four rotation products, each a 14 by 16 bit signed
	// multiply.
	// ------------------------------------------------------------------
	logic signed [PROD_W-1:0] pxc_s2;
	logic signed [PROD_W-1:0] pys_s2;
	logic signed [PROD_W-1:0] pxs_s2;
	logic signed [PROD_W-1:0] pyc_s2;
	logic signed [POS_W-1:0]  dcol_s2;
	logic signed [POS_W-1:0]  drow_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			pxc_s2  <= PROD_W'(cx_s1) * PROD_W'(cos_q);
			pys_s2  <= PROD_W'(cy_s1) * PROD_W'(sin_q);
			pxs_s2  <= PROD_W'(cx_s1) * PROD_W'(sin_q);
			pyc_s2  <= PROD_W'(cy_s1) * PROD_W'(cos_q);
			dcol_s2 <= dcol_s1;
			drow_s2 <= drow_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: combine the products into the rotated, still scaled,
	// column and row.
	// ------------------------------------------------------------------
	logic signed [SUM_W-1:0]  csum_s3;
	logic signed [SUM_W-1:0]  rsum_s3;
	logic signed [POS_W-1:0]  dcol_s3;
	logic signed [POS_W-1:0]  drow_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			csum_s3 <= SUM_W'(pxc_s2) - SUM_W'(pys_s2);
			rsum_s3 <= SUM_W'(pxs_s2) + SUM_W'(pyc_s2);
			dcol_s3 <= dcol_s2;
			drow_s3 <= drow_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: drop the fraction bits toward zero (a negative sum is biased
	// up by one less than the scale before the arithmetic shift), move the
	// origin to the source centre and pick the mapping of the mode.
	// ------------------------------------------------------------------
	localparam logic signed [SUM_W-1:0] TRUNC_BIAS = SUM_W'((1 << TRIG_FRAC_BITS) - 1);

	logic signed [SUM_W-1:0]  cbias;
	logic signed [SUM_W-1:0]  rbias;
	logic signed [SUM_W-1:0]  cshift;
	logic signed [SUM_W-1:0]  rshift;
	logic signed [POS_W-1:0]  rot_col;
	logic signed [POS_W-1:0]  rot_row;

	assign cbias   = csum_s3 + (csum_s3[SUM_W-1] ? TRUNC_BIAS : '0);
	assign rbias   = rsum_s3 + (rsum_s3[SUM_W-1] ? TRUNC_BIAS : '0);
	assign cshift  = cbias >>> TRIG_FRAC_BITS;
	assign rshift  = rbias >>> TRIG_FRAC_BITS;
	assign rot_col = POS_W'(cshift) + w_half;
	assign rot_row = POS_W'(rshift) + h_half;

	logic signed [POS_W-1:0]  col_s4;
	logic signed [POS_W-1:0]  row_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			col_s4 <= (mode_q == MODE_ANGLE) ? rot_col : dcol_s3;
			row_s4 <= (mode_q == MODE_ANGLE) ? rot_row : drow_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: bounds check against the source image, and the two address
	// products. The products use the low coordinate bits and only count
	// when the pixel is in range.
	// ------------------------------------------------------------------
	logic                     ok_s5;
	logic [COORD_W-1:0]       col_s5;
	logic [COORD_W-1:0]       row_s5;
	logic [ROWP_W-1:0]        rowp_s5;
	logic [COL3_W-1:0]        col3_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			ok_s5   <= !col_s4[POS_W-1] && (col_s4 < w_pos)
				&& !row_s4[POS_W-1] && (row_s4 < h_pos);
			col_s5  <= col_s4[COORD_W-1:0];
			row_s5  <= row_s4[COORD_W-1:0];
			rowp_s5 <= ROWP_W'(row_s4[COORD_W-1:0]) * ROWP_W'(stride_q);
			col3_s5 <= COL3_W'(col_s4[COORD_W-1:0]) * COL3_W'(BYTES_PER_PIXEL);
		end
	end

	// ------------------------------------------------------------------
	// Stage 6: output register. An out-of-range pixel reports zeros and a
	// cleared in_range flag.
	// ------------------------------------------------------------------
	logic [COORD_W-1:0]  col_s6;
	logic [COORD_W-1:0]  row_s6;
	logic [OFFSET_W-1:0] off_s6;
	logic                ok_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			ok_s6  <= ok_s5;
			col_s6 <= ok_s5 ? col_s5 : '0;
			row_s6 <= ok_s5 ? row_s5 : '0;
			off_s6 <= ok_s5 ? (OFFSET_W'(rowp_s5) + OFFSET_W'(col3_s5)) : '0;
		end
	end

	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = {off_s6, row_s6, col_s6};
	assign m_axis_tuser  = ok_s6;

endmodule

[sv/rsag_checker.sv]
`timescale 1ns / 1ps

module rsag_checker
	import rsag_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tready,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic                  m_axis_tuser
);

	// A result stalled by the consumer stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// A pixel outside the source reports zero coordinates and offset.
	a_out_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
		else $error("out-of-range result is not zero");

	// The offset of an in-range pixel never falls below its column term.
	a_off_min: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[55:26] >= 30'(m_axis_tdata[12:0]) * 30'(BYTES_PER_PIXEL))
		else $error("offset below column term");

	// With an empty output register the pipeline always takes new input.
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output register is empty");

endmodule

bind rotation_source_address_generator rsag_checker u_rsag_checker (.*);

[bench/rsag_address_checker.sv]
`timescale 1ns / 1ps

module rsag_address_checker
	import rsag_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [ADDR_W-1:0]     paddr,
	input  logic [DATA_W-1:0]     pwdata,

	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // dst_x[12:0], dst_y[25:13], zero fill

	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [OUT_DATA_W-1:0] m_axis_tdata,   // src_col[12:0], src_row[25:13],
	                                              // src_offset[55:26]
	input  logic                  m_axis_tuser,   // in_range[0]

	output int                    errors,
	output int                    pending,
	output int                    checked,
	output int                    outside
);

	typedef struct packed {
		logic [COORD_W-1:0]  col;
		logic [COORD_W-1:0]  row;
		logic [OFFSET_W-1:0] offset;
		logic                in_range;
	} src_addr_t;

	// Shadow copy of the register file, kept up to date by watching the write port.
	rot_mode_t                  mode;
	logic [DIM_W-1:0]           src_w;
	logic [DIM_W-1:0]           src_h;
	logic [DIM_W-1:0]           dst_w;
	logic [DIM_W-1:0]           dst_h;
	logic signed [TRIG_W-1:0]   cos_q;
	logic signed [TRIG_W-1:0]   sin_q;
	logic [STRIDE_W-1:0]        stride;

	src_addr_t pending_addrs[$];

	function automatic src_addr_t map_dst_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
		longint    w;
		longint    h;
		longint    cx;
		longint    cy;
		longint    one;
		longint    col;
		longint    row;
		src_addr_t r;
		w = (src_w > MAX_DIM) ? longint'(MAX_DIM) : longint'(src_w);
		h = (src_h > MAX_DIM) ? longint'(MAX_DIM) : longint'(src_h);
		one = longint'(1) << TRIG_FRAC_BITS;
		case (mode)
			MODE_ROT90: begin
				col = w - 1 - longint'(y);
				row = longint'(x);
			end
			MODE_ROT180: begin
				col = w - 1 - longint'(x);
				row = h - 1 - longint'(y);
			end
			MODE_ROT270: begin
				col = longint'(y);
				row = h - 1 - longint'(x);
			end
			default: begin
				// Integer division on signed operands rounds toward zero.
				cx = longint'(x) - longint'(dst_w >> 1);
				cy = longint'(y) - longint'(dst_h >> 1);
				col = (cx * longint'(cos_q) - cy * longint'(sin_q)) / one + w / 2;
				row = (cx * longint'(sin_q) + cy * longint'(cos_q)) / one + h / 2;
			end
		endcase
		r = '0;
		if (col >= 0 && col < w && row >= 0 && row < h) begin
			r.col      = COORD_W'(col);
			r.row      = COORD_W'(row);
			r.offset   = OFFSET_W'(row * longint'(stride) + col * BYTES_PER_PIXEL);
			r.in_range = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		src_addr_t want;
		src_addr_t got;
		if (!arst_n) begin
			mode    = MODE_ROT90;
			src_w   = DIM_W'(1);
			src_h   = DIM_W'(1);
			dst_w   = DIM_W'(1);
			dst_h   = DIM_W'(1);
			cos_q   = TRIG_W'(1 << TRIG_FRAC_BITS);
			sin_q   = '0;
			stride  = STRIDE_W'(1);
			pending_addrs.delete();
			errors  = 0;
			pending = 0;
			checked = 0;
			outside = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_MODE:       mode   = rot_mode_t'(pwdata[1:0]);
					REG_SRC_WIDTH:  src_w  = pwdata[DIM_W-1:0];
					REG_SRC_HEIGHT: src_h  = pwdata[DIM_W-1:0];
					REG_DST_WIDTH:  dst_w  = pwdata[DIM_W-1:0];
					REG_DST_HEIGHT: dst_h  = pwdata[DIM_W-1:0];
					REG_COS:        cos_q  = pwdata[TRIG_W-1:0];
					REG_SIN:        sin_q  = pwdata[TRIG_W-1:0];
					REG_STRIDE:     stride = pwdata[STRIDE_W-1:0];
					default: ;
				endcase
			end

			if (m_axis_tvalid && m_axis_tready) begin
				got.col      = m_axis_tdata[12:0];
				got.row      = m_axis_tdata[25:13];
				got.offset   = m_axis_tdata[55:26];
				got.in_range = m_axis_tuser;
				if (pending_addrs.size() == 0) begin
					errors++;
					$display("%0t: unexpected result col %0d row %0d offset %0d flag %0b",
						$time, got.col, got.row, got.offset, got.in_range);
				end else begin
					want = pending_addrs.pop_front();
					checked++;
					if (!want.in_range)
						outside++;
					if (got.col !== want.col) begin
						errors++;
						$display("%0t: src_col expected %0d, got %0d", $time, want.col, got.col);
					end
					if (got.row !== want.row) begin
						errors++;
						$display("%0t: src_row expected %0d, got %0d", $time, want.row, got.row);
					end
					if (got.offset !== want.offset) begin
						errors++;
						$display("%0t: src_offset expected %0d, got %0d", $time,
							want.offset, got.offset);
					end
					if (got.in_range !== want.in_range) begin
						errors++;
						$display("%0t: in_range expected %0b, got %0b", $time,
							want.in_range, got.in_range);
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready)
				pending_addrs.push_back(map_dst_pixel(s_axis_tdata[12:0], s_axis_tdata[25:13]));

			pending = pending_addrs.size();
		end
	end

endmodule

[bench/rotation_source_address_generator_tb.sv]
`timescale 1ns / 1ps

module rotation_source_address_generator_tb;
	import rsag_pkg::*;

	// Length of the deliberate output stall, long enough to back the pipeline up to its input.
	localparam int STALL_CYCLES = 64;
	localparam int RANDOM_PHASES = 12;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_W-1:0]     paddr;
	logic [DATA_W-1:0]     pwdata;
	logic [DATA_W-1:0]     prdata;
	logic                  pready;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;   // dst_x[12:0], dst_y[25:13], zero fill
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;   // src_col[12:0], src_row[25:13], src_offset[55:26]
	logic                  m_axis_tuser;   // in_range[0]

	int errors;
	int pending;
	int checked;
	int outside;

	// Shared control between the input driver and the output-side ready process.
	bit quiet = 1'b0;        // no idling on either side while set
	bit stall_req = 1'b0;    // asks the ready process for one long hold-off
	int settings = 1;        // register settings used so far, the reset one included

	// The register values last written, used to aim coordinates at the interesting region.
	rot_mode_t cur_mode;
	int cur_sw;
	int cur_sh;
	int cur_dw;
	int cur_dh;

	always #4 clk = ~clk;

	rotation_source_address_generator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	rsag_address_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.pready        (pready),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.errors        (errors),
		.pending       (pending),
		.checked       (checked),
		.outside       (outside)
	);

	// Output side: ready drops about a third of the time, except in the quiet stretch.
	// A stall request turns into a long hold-off that this process counts down itself.
	initial begin
		int hold_left;
		bit stall_taken;
		hold_left = 0;
		stall_taken = 1'b0;
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_req && !stall_taken) begin
				hold_left = STALL_CYCLES;
				stall_taken = 1'b1;
			end
			if (!arst_n) begin
				m_axis_tready <= 1'b0;
			end else if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= quiet || ($urandom_range(0, 99) >= 33);
			end
		end
	end

	// Offers one destination pixel and returns at the edge where the transfer is taken.
	// Valid only drops when a gap is inserted, so back-to-back pixels keep it high.
	task automatic send_pixel(input int x, input int y);
		int gap;
		gap = 0;
		if (!quiet && $urandom_range(0, 99) < 33)
			gap = $urandom_range(1, 3);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, 13'(y), 13'(x)};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stops offering pixels and waits until every predicted address has come back.
	// The count is read at the falling edge, after the checker has settled.
	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Every phase rewrites the whole register file, and only once the pipeline is empty.
	// Each pixel always yields a result, so an empty queue means the block is idle.
	task automatic configure(input rot_mode_t m, input int sw, input int sh, input int dw,
			input int dh, input int c, input int s, input int stride);
		drain_pipeline();
		write_reg(REG_MODE, int'(m));
		write_reg(REG_SRC_WIDTH, sw);
		write_reg(REG_SRC_HEIGHT, sh);
		write_reg(REG_DST_WIDTH, dw);
		write_reg(REG_DST_HEIGHT, dh);
		write_reg(REG_COS, c);
		write_reg(REG_SIN, s);
		write_reg(REG_STRIDE, stride);
		cur_mode = m;
		cur_sw = sw;
		cur_sh = sh;
		cur_dw = dw;
		cur_dh = dh;
		settings++;
	endtask

	// Mostly small images so that many pixels land inside the source, with the odd
	// zero size, the largest legal size and sizes above it that the block clamps.
	function automatic int pick_dim();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom_range(1, 96);
		else if (r < 80)
			return $urandom_range(97, 8192);
		else if (r < 86)
			return 0;
		else if (r < 93)
			return 8192;
		else
			return $urandom_range(8193, 16383);
	endfunction

	// Coordinates cluster just around the span that can map inside the source.
	// One in five covers the whole 13-bit field so every bit takes both values.
	function automatic int pick_coord(input int span);
		int lim;
		lim = span + 2;
		if (lim > 8192)
			lim = 8192;
		if ($urandom_range(0, 4) == 0)
			return $urandom_range(0, 8191);
		return $urandom_range(0, lim - 1);
	endfunction

	task automatic random_setup();
		int cos_tab[5];
		int sin_tab[5];
		int k;
		int c;
		int s;
		int sw;
		int sh;
		int dw;
		int dh;
		int stride;
		rot_mode_t m;
		// Cosine and sine at 0, 30, 45, 60 and 90 degrees in Q1.14.
		cos_tab = '{16384, 14189, 11585, 8192, 0};
		sin_tab = '{0, 8192, 11585, 14189, 16384};
		m  = rot_mode_t'($urandom_range(0, 3));
		sw = pick_dim();
		sh = pick_dim();
		if ($urandom_range(0, 1) == 0) begin
			dw = sw;
			dh = sh;
		end else begin
			dw = pick_dim();
			dh = pick_dim();
		end
		if ($urandom_range(0, 4) == 0) begin
			// Arbitrary trig values, well outside the unit circle included.
			c = $urandom_range(0, 65535);
			s = $urandom_range(0, 65535);
		end else begin
			k = $urandom_range(0, 4);
			c = ($urandom_range(0, 1) == 1) ? -cos_tab[k] : cos_tab[k];
			s = ($urandom_range(0, 1) == 1) ? -sin_tab[k] : sin_tab[k];
		end
		case ($urandom_range(0, 9))
			0:       stride = 0;
			1:       stride = 65535;
			default: stride = (sw * BYTES_PER_PIXEL + $urandom_range(0, 64)) & 16'hFFFF;
		endcase
		configure(m, sw, sh, dw, dh, c, s, stride);
	endtask

	initial begin
		int n_items;
		int span_x;
		int span_y;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: quarter turn on a one-pixel source, so only the origin lands.
		send_pixel(0, 0);
		send_pixel(1, 0);
		send_pixel(0, 1);
		send_pixel(8191, 8191);
		send_pixel(5461, 2730);

		// Half turn on the largest source with the widest stride: corners and far edges.
		configure(MODE_ROT180, 8192, 8192, 1, 1, 16384, 0, 65535);
		send_pixel(0, 0);
		send_pixel(8191, 8191);
		send_pixel(8191, 0);
		send_pixel(0, 8191);

		// Three-quarter turn with an oversized width that must count as the maximum.
		configure(MODE_ROT270, 16383, 100, 1, 1, 16384, 0, 300);
		send_pixel(0, 0);
		send_pixel(99, 8191);
		send_pixel(100, 5);

		// A zero-width source leaves nothing in range.
		configure(MODE_ROT90, 0, 50, 1, 1, 16384, 0, 1);
		send_pixel(0, 0);

		// Arbitrary angle with the most negative cosine and the largest sine.
		configure(MODE_ANGLE, 8192, 8192, 16383, 16383, -32768, 32767, 12345);
		send_pixel(0, 0);
		send_pixel(8191, 8191);
		send_pixel(8191, 0);
		send_pixel(0, 8191);

		// Identity angle on a matching image, corners and just past the far corner.
		configure(MODE_ANGLE, 640, 480, 640, 480, 16384, 0, 1920);
		send_pixel(320, 240);
		send_pixel(0, 0);
		send_pixel(639, 479);
		send_pixel(640, 480);

		// Minus 45 degrees: negative products must truncate toward zero, not down.
		configure(MODE_ANGLE, 64, 64, 64, 64, 11585, -11585, 192);
		send_pixel(1, 32);
		send_pixel(63, 0);

		// Random phases. One runs with no idling at all, another takes a long output stall.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			random_setup();
			quiet = (p == 3);
			n_items = (p == 3) ? 200 : 120;
			case (cur_mode)
				MODE_ROT90, MODE_ROT270: begin
					span_x = cur_sh;
					span_y = cur_sw;
				end
				MODE_ROT180: begin
					span_x = cur_sw;
					span_y = cur_sh;
				end
				default: begin
					span_x = cur_dw;
					span_y = cur_dh;
				end
			endcase
			for (int i = 0; i < n_items; i++) begin
				if (p == 6 && i == 40)
					stall_req = 1'b1;
				send_pixel(pick_coord(span_x), pick_coord(span_y));
			end
		end
		quiet = 1'b0;

		drain_pipeline();
		repeat (12) @(posedge clk);

		$display("Checked %0d source addresses over %0d register settings, %0d outside the source.",
			checked, settings, outside);
		$display("Covered all four modes, zero and clamped sizes, extreme trig and stride values,");
		$display("a long output stall and a stretch with no idling.");
		if (errors == 0 && pending == 0)
			$display("** rotation_source_address_generator: PASSED **");
		else
			$display("** rotation_source_address_generator: FAILED **");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2000000;
		$display("** rotation_source_address_generator: FAILED **");
		$finish;
	end

endmodule

[rotation_source_address_generator.f]
sv/rsag_pkg.sv
sv/rotation_source_address_generator.sv
sv/rsag_checker.sv
bench/rsag_address_checker.sv
bench/rotation_source_address_generator_tb.sv
